>>> rtl/core/stw_pkg.sv
// Shared constants and types for the sliding window trend statistics block.
// No dependencies.
`default_nettype none
package stw_pkg;

    localparam int SAMPLE_W     = 18;
    localparam int MAX_PERIOD   = 255;
    localparam int PERIOD_W     = 8;
    localparam int ADDR_W       = 8;
    localparam int DEPTH        = 1 << ADDR_W;
    localparam int SEEN_W       = 9;
    localparam int SUM_W        = 26;
    localparam int PIS_W        = 28;
    localparam int SQS_W        = 42;
    localparam int DIV_NW       = 44;
    localparam int DIV_DW       = 19;
    localparam int ROOT_W       = DIV_NW / 2;
    localparam int PCT_W        = 26;
    localparam int SWC_W        = 16;
    localparam int MEAN_W       = 19;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd7;
    localparam logic [SEEN_W-1:0]   SEEN_MAX     = SEEN_W'(MAX_PERIOD + 2);

    typedef enum logic [1:0] {
        KIND_FINITE  = 2'd0,
        KIND_POS_INF = 2'd1,
        KIND_NEG_INF = 2'd2,
        KIND_UNDEF   = 2'd3
    } t_evo_kind;

endpackage
`default_nettype wire

>>> rtl/core/sliding_window_trend_statistics_top.sv
// Top level: sample window memory, window sweep, sequencer, result register.
// Depends on stw_pkg, stw_div and stw_sqrt.
//
// channel  direction  handshake                 payload
// input    in         i_in_valid / o_in_stall   i_sample
// output   out        o_out_valid / i_out_stall o_increase_mean .. o_switch_total
// config   in         i_cfg_we                  i_cfg_wdata (window_period)
//
// A full item runs a window sweep (one memory read a cycle), four serial divisions,
// a serial square root and the sequencing states. A zero old sample skips one division;
// with no evolution yet the last two divisions are skipped; before p samples an item
// goes straight to the output register.
// Reset is synchronous and clears all control state; the window needs no clearing.
// A stalled result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module sliding_window_trend_statistics_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [stw_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [stw_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [17:0]                        o_increase_mean,
    output logic                               o_increase_mean_valid,
    output logic signed [stw_pkg::PCT_W-1:0]   o_evolution_percent,
    output logic [1:0]                         o_evolution_kind,
    output logic                               o_evolution_valid,
    output logic [17:0]                        o_std_deviation,
    output logic                               o_std_deviation_valid,
    output logic                               o_switch_occurs,
    output logic [stw_pkg::SWC_W-1:0]          o_switch_total
);

    localparam int SW = stw_pkg::SAMPLE_W;
    localparam int NW = stw_pkg::DIV_NW;
    localparam int AW = stw_pkg::ADDR_W;
    localparam int PW = stw_pkg::PERIOD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_DRAIN, S_DIVM, S_MUL1, S_MUL2, S_SUMS,
        S_DIVS, S_SQRT, S_DIVI, S_DIVP, S_SWITCH, S_DONE
    } t_state;

    t_state r_state;

    logic signed [SW-1:0] r_win [stw_pkg::DEPTH];

    logic [PW-1:0]               r_period;
    logic [AW-1:0]               r_wp;
    logic [stw_pkg::SEEN_W-1:0]  r_seen;
    logic [PW-1:0]               r_p;
    logic [PW-1:0]               r_klast;
    logic [PW-1:0]               r_k;
    logic                        r_ev;
    logic                        r_sd;
    logic                        r_first;
    logic signed [SW-1:0]        r_x;

    logic signed [SW-1:0]        r_q;
    logic [PW-1:0]               r_qk;
    logic                        r_qv;
    logic signed [SW-1:0]        r_prev;
    logic signed [SW-1:0]        r_old;
    logic signed [stw_pkg::SUM_W-1:0] r_sum;
    logic [stw_pkg::SQS_W-1:0]   r_sqs;
    logic [stw_pkg::PIS_W-1:0]   r_pis;

    logic signed [stw_pkg::MEAN_W-1:0] r_m;
    logic [NW-1:0]               r_t1;
    logic signed [2*stw_pkg::MEAN_W-1:0] r_t2;
    logic [NW-1:0]               r_t3;
    logic [NW-1:0]               r_t4;

    logic                        r_div_start;
    logic [NW-1:0]               r_div_num;
    logic [stw_pkg::DIV_DW-1:0]  r_div_den;
    logic                        r_sqrt_start;
    logic [NW-1:0]               r_sqrt_rad;

    logic [17:0]                 r_incr;
    logic signed [stw_pkg::PCT_W-1:0] r_pct;
    stw_pkg::t_evo_kind          r_kind;
    logic [17:0]                 r_std;
    logic                        r_sw;
    logic                        r_last_neg;
    logic [stw_pkg::SWC_W-1:0]   r_swc;

    logic                        r_out_valid;
    logic [17:0]                 r_o_incr;
    logic signed [stw_pkg::PCT_W-1:0] r_o_pct;
    stw_pkg::t_evo_kind          r_o_kind;
    logic                        r_o_ev;
    logic [17:0]                 r_o_std;
    logic                        r_o_sd;
    logic                        r_o_sw;
    logic [stw_pkg::SWC_W-1:0]   r_o_swc;

    logic                        div_done;
    logic [NW-1:0]               div_quo;
    logic                        sqrt_done;
    logic [stw_pkg::ROOT_W-1:0]  sqrt_root;

    logic                        in_acc;
    logic [stw_pkg::SEEN_W-1:0]  n_seen;
    logic [PW-1:0]               n_p;
    logic [AW-1:0]               rd_addr;
    logic [SW-1:0]               q_mag;
    logic signed [SW:0]          step;
    logic [stw_pkg::SUM_W-1:0]   sum_mag;
    logic signed [SW:0]          diff;
    logic signed [stw_pkg::PCT_W-1:0] diff100;
    logic [stw_pkg::PCT_W-1:0]   diff100_mag;
    logic [SW-1:0]               old_mag;
    logic [NW-1:0]               s_val;
    logic                        neg;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign n_seen  = (r_seen < stw_pkg::SEEN_MAX) ? r_seen + stw_pkg::SEEN_W'(1) : r_seen;
    assign n_p     = (r_period == '0) ? PW'(1) : r_period;
    assign rd_addr = r_wp - AW'(1) - AW'(r_k);
    assign q_mag   = r_q[SW-1] ? SW'(-r_q) : SW'(r_q);
    assign step    = (SW+1)'(r_prev) - (SW+1)'(r_q);
    assign sum_mag = r_sum[stw_pkg::SUM_W-1] ? stw_pkg::SUM_W'(-r_sum)
                                             : stw_pkg::SUM_W'(r_sum);
    assign diff    = (SW+1)'(r_x) - (SW+1)'(r_old);
    assign diff100 = stw_pkg::PCT_W'(diff) * stw_pkg::PCT_W'(100);
    assign diff100_mag = diff100[stw_pkg::PCT_W-1] ? stw_pkg::PCT_W'(-diff100)
                                                   : stw_pkg::PCT_W'(diff100);
    assign old_mag = r_old[SW-1] ? SW'(-r_old) : SW'(r_old);
    assign s_val   = r_t4 + r_t3;
    assign neg     = (r_old == '0) ? (r_kind == stw_pkg::KIND_NEG_INF)
                                   : r_pct[stw_pkg::PCT_W-1];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win[r_wp] <= i_sample;
        end
        r_q <= r_win[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= stw_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else begin
            r_qv <= (r_state == S_LOOP);
        end
        r_qk <= r_k;
        if (in_acc) begin
            r_sum <= '0;
            r_sqs <= '0;
            r_pis <= '0;
            r_old <= '0;
        end else if (r_qv) begin
            r_prev <= r_q;
            if (r_qk < r_p) begin
                r_sum <= r_sum + stw_pkg::SUM_W'(r_q);
                r_sqs <= r_sqs + stw_pkg::SQS_W'(q_mag * q_mag);
            end
            if (r_qk != '0 && step > 0) begin
                r_pis <= r_pis + stw_pkg::PIS_W'(step);
            end
            if (r_qk == r_p) begin
                r_old <= r_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_seen       <= '0;
            r_last_neg   <= 1'b0;
            r_swc        <= '0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_start  <= ((r_state == S_DRAIN) && !r_qv) || (r_state == S_SUMS)
                         || ((r_state == S_SQRT) && sqrt_done && r_ev)
                         || ((r_state == S_DIVI) && div_done && (r_old != '0));
            r_sqrt_start <= (r_state == S_DIVS) && div_done;
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wp    <= r_wp + AW'(1);
                        r_seen  <= n_seen;
                        r_p     <= n_p;
                        r_ev    <= n_seen > stw_pkg::SEEN_W'(n_p);
                        r_sd    <= n_seen >= stw_pkg::SEEN_W'(n_p);
                        r_first <= n_seen == stw_pkg::SEEN_W'(n_p) + stw_pkg::SEEN_W'(1);
                        r_klast <= (n_seen > stw_pkg::SEEN_W'(n_p)) ? n_p : n_p - PW'(1);
                        r_x     <= i_sample;
                        r_k     <= '0;
                        r_incr  <= '0;
                        r_pct   <= '0;
                        r_kind  <= stw_pkg::KIND_FINITE;
                        r_std   <= '0;
                        r_sw    <= 1'b0;
                        r_state <= (n_seen >= stw_pkg::SEEN_W'(n_p)) ? S_LOOP : S_DONE;
                    end
                end
                S_LOOP: begin
                    r_k <= r_k + PW'(1);
                    if (r_k == r_klast) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_qv) begin
                        r_div_num   <= NW'({sum_mag, 1'b0}) + NW'(r_p);
                        r_div_den   <= stw_pkg::DIV_DW'({r_p, 1'b0});
                        r_state     <= S_DIVM;
                    end
                end
                S_DIVM: begin
                    if (div_done) begin
                        r_m <= r_sum[stw_pkg::SUM_W-1] ? stw_pkg::MEAN_W'(-div_quo)
                                                       : stw_pkg::MEAN_W'(div_quo);
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_t1    <= NW'(r_m * r_sum);
                    r_t2    <= r_m * r_m;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_t3    <= NW'($unsigned(r_t2)) * NW'(r_p);
                    r_t4    <= NW'(r_sqs) - {r_t1[NW-2:0], 1'b0};
                    r_state <= S_SUMS;
                end
                S_SUMS: begin
                    r_div_num   <= {s_val[NW-3:0], 2'b00};
                    r_div_den   <= stw_pkg::DIV_DW'(r_p);
                    r_state     <= S_DIVS;
                end
                S_DIVS: begin
                    if (div_done) begin
                        r_sqrt_rad   <= div_quo;
                        r_state      <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_std <= 18'((sqrt_root + stw_pkg::ROOT_W'(1)) >> 1);
                        if (r_ev) begin
                            r_div_num   <= NW'({r_pis, 1'b0}) + NW'(r_p);
                            r_div_den   <= stw_pkg::DIV_DW'({r_p, 1'b0});
                            r_state     <= S_DIVI;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIVI: begin
                    if (div_done) begin
                        r_incr <= div_quo[17:0];
                        if (r_old == '0) begin
                            priority if (diff > 0) begin
                                r_kind <= stw_pkg::KIND_POS_INF;
                            end else if (diff < 0) begin
                                r_kind <= stw_pkg::KIND_NEG_INF;
                            end else begin
                                r_kind <= stw_pkg::KIND_UNDEF;
                            end
                            r_state <= S_SWITCH;
                        end else begin
                            r_div_num   <= NW'({diff100_mag, 1'b0}) + NW'(old_mag);
                            r_div_den   <= {old_mag, 1'b0};
                            r_state     <= S_DIVP;
                        end
                    end
                end
                S_DIVP: begin
                    if (div_done) begin
                        r_pct <= diff[SW] ? stw_pkg::PCT_W'(-div_quo)
                                          : stw_pkg::PCT_W'(div_quo);
                        r_state <= S_SWITCH;
                    end
                end
                S_SWITCH: begin
                    if (!r_first && neg != r_last_neg) begin
                        r_sw <= 1'b1;
                        if (r_swc != '1) begin
                            r_swc <= r_swc + stw_pkg::SWC_W'(1);
                        end
                    end
                    r_last_neg <= neg;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_incr    <= r_incr;
                        r_o_pct     <= r_pct;
                        r_o_kind    <= r_kind;
                        r_o_ev      <= r_ev;
                        r_o_std     <= r_std;
                        r_o_sd      <= r_sd;
                        r_o_sw      <= r_sw;
                        r_o_swc     <= r_swc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    stw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    stw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_rad   (r_sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_increase_mean       = r_o_incr;
    assign o_increase_mean_valid = r_o_ev;
    assign o_evolution_percent   = r_o_pct;
    assign o_evolution_kind      = r_o_kind;
    assign o_evolution_valid     = r_o_ev;
    assign o_std_deviation       = r_o_std;
    assign o_std_deviation_valid = r_o_sd;
    assign o_switch_occurs       = r_o_sw;
    assign o_switch_total        = r_o_swc;

endmodule
`default_nettype wire

>>> rtl/core/stw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on stw_pkg for operand widths.
`default_nettype none
module stw_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [stw_pkg::DIV_NW-1:0]  i_num,
    input  wire logic [stw_pkg::DIV_DW-1:0]  i_den,
    output logic                             o_done,
    output logic [stw_pkg::DIV_NW-1:0]       o_quo
);

    localparam int CNT_W = $clog2(stw_pkg::DIV_NW);

    logic [stw_pkg::DIV_NW-1:0] r_work;
    logic [stw_pkg::DIV_DW-1:0] r_rem;
    logic [stw_pkg::DIV_DW-1:0] r_den;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [stw_pkg::DIV_DW:0]   n_shift;
    logic [stw_pkg::DIV_DW:0]   n_trial;

    always_comb begin
        n_shift = {r_rem, r_work[stw_pkg::DIV_NW-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(stw_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!n_trial[stw_pkg::DIV_DW]) begin
                r_rem  <= n_trial[stw_pkg::DIV_DW-1:0];
                r_work <= {r_work[stw_pkg::DIV_NW-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift[stw_pkg::DIV_DW-1:0];
                r_work <= {r_work[stw_pkg::DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_work;

endmodule
`default_nettype wire

>>> rtl/core/stw_sqrt.sv
// Restoring integer square root, one root bit per cycle.
// Depends on stw_pkg for operand widths.
`default_nettype none
module stw_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [stw_pkg::DIV_NW-1:0]  i_rad,
    output logic                             o_done,
    output logic [stw_pkg::ROOT_W-1:0]       o_root
);

    localparam int REM_W = stw_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(stw_pkg::ROOT_W);

    logic [stw_pkg::DIV_NW-1:0] r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [stw_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [REM_W-1:0]           n_shift;
    logic [REM_W-1:0]           n_trial;

    always_comb begin
        n_shift = {r_rem[REM_W-3:0], r_rad[stw_pkg::DIV_NW-1 -: 2]};
        n_trial = REM_W'({r_root, 2'b01});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(stw_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[stw_pkg::DIV_NW-3:0], 2'b00};
            if (n_shift >= n_trial) begin
                r_rem  <= n_shift - n_trial;
                r_root <= {r_root[stw_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_root <= {r_root[stw_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

>>> rtl/core/stw_checker.sv
// Port-level checks for the trend statistics top level, with its bind.
// Depends on stw_pkg and sliding_window_trend_statistics_top.
`default_nettype none
module stw_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_out_stall,
    input  wire logic                          o_out_valid,
    input  wire logic [17:0]                   o_increase_mean,
    input  wire logic                          o_increase_mean_valid,
    input  wire logic signed [stw_pkg::PCT_W-1:0] o_evolution_percent,
    input  wire logic [1:0]                    o_evolution_kind,
    input  wire logic                          o_evolution_valid,
    input  wire logic [17:0]                   o_std_deviation,
    input  wire logic                          o_std_deviation_valid,
    input  wire logic                          o_switch_occurs,
    input  wire logic [stw_pkg::SWC_W-1:0]     o_switch_total
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_std_deviation)
            && $stable(o_switch_total))
        else $error("stalled transfer changed");

    a_valid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_evolution_valid == o_increase_mean_valid)
        else $error("evolution and increase valid differ");

    a_sd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evolution_valid |-> o_std_deviation_valid)
        else $error("deviation not valid with evolution");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evolution_valid |-> !o_switch_occurs
            && o_evolution_percent == '0 && o_evolution_kind == '0
            && o_increase_mean == '0)
        else $error("invalid evolution carries data");

    a_switch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switch_occurs |-> o_switch_total != '0)
        else $error("switch without count");

endmodule

bind sliding_window_trend_statistics_top stw_checker u_stw_checker (.*);
`default_nettype wire
